FILE: rtl/lstc_pkg.sv
// Package for the line sensor threshold calibrator.
// Field widths, defaults, opcodes and the per-sensor store entry type.
// No dependencies.
package lstc_pkg;

    localparam int SENSOR_COUNT_DEF = 8;
    localparam int SWEEPS_DEF       = 128;
    localparam int SAMPLE_MAX_DEF   = 1023;

    localparam int IDX_W = 3;
    localparam int SMP_W = 10;
    localparam int VAL_W = 16;
    localparam int SUM_W = 16;
    localparam int CNT_W = 7;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = 7'd127;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] thr;
        logic [VAL_W-1:0] min_v;
        logic [VAL_W-1:0] max_v;
        logic [SUM_W-1:0] wsum;
        logic [SUM_W-1:0] bsum;
        logic [CNT_W-1:0] wcnt;
        logic [CNT_W-1:0] bcnt;
    } t_entry;

endpackage

FILE: rtl/line_sensor_threshold_calibrator.sv
// Top level of the line sensor threshold calibrator.
// Sequencer and update logic around lstc_mem and two lstc_div units; uses lstc_pkg.
//
//  channel   dir  tdata                                      tuser       tlast
//  s_axis    in   [2:0] index, [12:3] sample                 opcode      end of sweep
//  m_axis    out  [2:0] sensor, [12:3] thr, [22:13] lo,      calibrated  -
//                 [32:23] hi
//
// An item passes through accept, state memory read, and write back with result load.
// A sample in the last calibration sweep also passes through the divide step for the mean dividers.
// Reset and the clear opcode invalidate every memory entry by clearing all valid bits.
// A stalled output holds the block in write back; one item is in flight at a time.
module line_sensor_threshold_calibrator
    import lstc_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int SWEEPS       = SWEEPS_DEF,
    parameter int SAMPLE_MAX   = SAMPLE_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // sensor_index, sample
    input  logic                   s_axis_tuser,   // opcode
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // sensor_number, threshold, lowest, highest
    output logic                   m_axis_tuser    // calibrated
);

    localparam int AW = $clog2(SENSOR_COUNT);
    localparam int SW = $clog2(SWEEPS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic             r_op;
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_v;
    logic             r_eos;
    logic             r_in_range;
    logic [SW-1:0]    r_sweep, n_sweep;
    t_entry           r_ent;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [SMP_W-1:0] r_out_thr;
    logic [SMP_W-1:0] r_out_lo;
    logic [SMP_W-1:0] r_out_hi;
    logic             r_out_cal;

    logic             accept;
    logic [IDX_W-1:0] in_idx;
    logic [SMP_W-1:0] in_smp;
    logic             in_range;
    logic             rd_en;
    t_entry           rd_data;
    logic             rd_hit;
    logic             wr_en;
    logic             mem_clear;
    logic             out_free;

    t_entry           ent, upd;
    logic [VAL_W:0]   mid;
    logic             is_half, is_accum, is_final;
    logic [SUM_W:0]   wsum_n, bsum_n;
    logic             div_start;
    logic             wdone, bdone;
    logic [SUM_W-1:0] wq, bq;
    logic [VAL_W:0]   mean_sum;

    assign in_idx   = s_axis_tdata[IDX_W-1:0];
    assign in_smp   = s_axis_tdata[IDX_W+SMP_W-1:IDX_W];
    assign in_range = (32'(in_idx) < SENSOR_COUNT);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign rd_en    = accept && (s_axis_tuser == OP_SAMPLE) && in_range;
    assign out_free = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    lstc_mem #(
        .DEPTH (SENSOR_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (mem_clear),
        .i_rd_en   (rd_en),
        .i_rd_addr (AW'(in_idx)),
        .o_rd_data (rd_data),
        .o_rd_hit  (rd_hit),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_idx)),
        .i_wr_data (r_ent)
    );

    // read-modify of one entry; the memory word arrives in ST_READ
    always_comb begin
        ent = rd_data;
        if (!rd_hit) begin
            ent       = '0;
            ent.min_v = VAL_W'(SAMPLE_MAX);
        end
        is_half  = (r_sweep == SW'(SWEEPS / 2));
        is_accum = (r_sweep > SW'(SWEEPS / 2)) && (r_sweep < SW'(SWEEPS));
        is_final = (r_sweep == SW'(SWEEPS - 1));
        mid      = {1'b0, ent.max_v} + {1'b0, ent.min_v};
        upd      = ent;
        if (is_half) begin
            upd.thr = mid[VAL_W:1];
        end
        wsum_n = {1'b0, ent.wsum} + {1'b0, r_v};
        bsum_n = {1'b0, ent.bsum} + {1'b0, r_v};
        if (is_accum && (r_v < upd.thr) && (ent.wcnt < COUNT_LIMIT) && !wsum_n[SUM_W]) begin
            upd.wsum = wsum_n[SUM_W-1:0];
            upd.wcnt = ent.wcnt + 1'b1;
        end
        if (is_accum && (r_v > upd.thr) && (ent.bcnt < COUNT_LIMIT) && !bsum_n[SUM_W]) begin
            upd.bsum = bsum_n[SUM_W-1:0];
            upd.bcnt = ent.bcnt + 1'b1;
        end
        if (r_v > ent.max_v) begin
            upd.max_v = r_v;
        end
        if (r_v < ent.min_v) begin
            upd.min_v = r_v;
        end
    end

    assign div_start = (r_state == ST_READ) && (r_op == OP_SAMPLE) && r_in_range && is_final;

    lstc_div u_div_white (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (upd.wsum),
        .i_divisor  (upd.wcnt),
        .o_done     (wdone),
        .o_quotient (wq)
    );

    lstc_div u_div_black (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (upd.bsum),
        .i_divisor  (upd.bcnt),
        .o_done     (bdone),
        .o_quotient (bq)
    );

    assign mean_sum = {1'b0, wq} + {1'b0, bq};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = div_start ? ST_DIV : ST_WRITE;
            end
            ST_DIV: begin
                if (wdone && bdone) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign wr_en     = (r_state == ST_WRITE) && out_free && (r_op == OP_SAMPLE) && r_in_range;
    assign mem_clear = (r_state == ST_WRITE) && out_free && (r_op == OP_CLEAR);

    always_comb begin
        n_sweep = r_sweep;
        if (r_op == OP_CLEAR) begin
            n_sweep = '0;
        end else if (r_eos && (r_sweep < SW'(SWEEPS))) begin
            n_sweep = r_sweep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_WRITE) && out_free) begin
                r_sweep     <= n_sweep;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= s_axis_tuser;
            r_idx      <= in_idx;
            r_eos      <= s_axis_tlast;
            r_in_range <= in_range;
            if (32'(in_smp) > SAMPLE_MAX) begin
                r_v <= VAL_W'(SAMPLE_MAX);
            end else begin
                r_v <= VAL_W'(in_smp);
            end
        end
        if (r_state == ST_READ) begin
            r_ent <= upd;
        end
        if ((r_state == ST_DIV) && wdone) begin
            r_ent.thr <= mean_sum[VAL_W:1];
        end
        if ((r_state == ST_WRITE) && out_free) begin
            r_out_cal <= (n_sweep >= SW'(SWEEPS));
            if (r_op == OP_CLEAR) begin
                r_out_idx <= '0;
                r_out_thr <= '0;
                r_out_lo  <= SMP_W'(SAMPLE_MAX);
                r_out_hi  <= '0;
            end else if (r_in_range) begin
                r_out_idx <= r_idx;
                r_out_thr <= r_ent.thr[SMP_W-1:0];
                r_out_lo  <= r_ent.min_v[SMP_W-1:0];
                r_out_hi  <= r_ent.max_v[SMP_W-1:0];
            end else begin
                r_out_idx <= r_idx;
                r_out_thr <= '0;
                r_out_lo  <= '0;
                r_out_hi  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_cal;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - IDX_W - 3 * SMP_W)'(0), r_out_hi, r_out_lo, r_out_thr, r_out_idx
    };

    a_div_only_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == ST_DIV))
        else $error("divider started outside the read step");

    a_no_write_on_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_op == OP_SAMPLE) && !mem_clear)
        else $error("memory write during a clear transaction");

    a_sweep_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweep <= SW'(SWEEPS))
        else $error("sweep count past its limit");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_WRITE))
        else $error("result loaded outside write back");

    a_cal_matches_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && m_axis_tvalid |-> (m_axis_tuser == (r_sweep >= SW'(SWEEPS))))
        else $error("calibrated flag disagrees with sweep count");

endmodule

FILE: rtl/lstc_div.sv
// Restoring divider, one quotient bit per cycle, for the class means.
// A zero divisor gives a quotient of zero. Depends on lstc_pkg.
module lstc_div
    import lstc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);

    localparam int CW = $clog2(SUM_W + 1);

    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_zero;
    logic [CNT_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_rem;
    logic [SUM_W-1:0] r_q;
    logic [CNT_W:0]   sh;
    logic             fits;

    assign sh   = {r_rem, r_q[SUM_W-1]};
    assign fits = (sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= CNT_W'(sh - {1'b0, r_dvs});
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= sh[CNT_W-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_zero ? '0 : r_q;

endmodule

FILE: rtl/lstc_mem.sv
// Per-sensor state memory: one entry per sensor, registered read port,
// one write port, and valid bits so a clear invalidates all entries together. Uses lstc_pkg.
module lstc_mem
    import lstc_pkg::*;
#(
    parameter int DEPTH = SENSOR_COUNT_DEF,
    parameter int AW    = $clog2(SENSOR_COUNT_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    output logic          o_rd_hit,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry           mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_entry           r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_hit  = r_rd_hit;

endmodule

FILE: dv/tb_top.sv
// Testbench for line_sensor_threshold_calibrator: streams clear and sample transactions
// through a clocked driver and checks every report against an in-bench calibration model.
// Depends on lstc_pkg and the calibrator RTL.
module tb_top;
    import lstc_pkg::*;

    localparam int SENSORS     = SENSOR_COUNT_DEF;
    localparam int SWEEPS      = SWEEPS_DEF;
    localparam int HALF_SWEEP  = SWEEPS / 2;
    localparam int SUM_CAP     = 65535;
    localparam int IDLE_PCT    = 36;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] idx;
        logic [SMP_W-1:0] smp;
        logic             eos;
    } t_sweep_item;

    typedef struct packed {
        logic [IDX_W-1:0] sensor;
        logic [SMP_W-1:0] thr;
        logic [SMP_W-1:0] lo;
        logic [SMP_W-1:0] hi;
        logic             cal;
    } t_report;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [2:0] sensor_index, [12:3] sample
    logic                   s_axis_tuser  = 1'b0; // opcode
    logic                   s_axis_tlast  = 1'b0; // end_of_sweep
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [2:0] sensor, [12:3] thr, [22:13] lo, [32:23] hi
    logic                   m_axis_tuser;  // calibrated

    line_sensor_threshold_calibrator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // calibration model state
    int hi_m[SENSORS];
    int lo_m[SENSORS];
    int thr_m[SENSORS];
    int wsum_m[SENSORS];
    int bsum_m[SENSORS];
    int wcnt_m[SENSORS];
    int bcnt_m[SENSORS];
    int sweeps_m;

    t_sweep_item pending_items[$];
    t_report     expected_reports[$];
    int          mismatches   = 0;
    int          reports_seen = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          in_taken     = 1'b0;
    bit          offering     = 1'b0;

    wire burst_mode = (reports_seen >= 300) && (reports_seen < 420);

    function automatic void clear_calibration();
        for (int k = 0; k < SENSORS; k++) begin
            hi_m[k]   = 0;
            lo_m[k]   = SAMPLE_MAX_DEF;
            thr_m[k]  = 0;
            wsum_m[k] = 0;
            bsum_m[k] = 0;
            wcnt_m[k] = 0;
            bcnt_m[k] = 0;
        end
        sweeps_m = 0;
    endfunction

    function automatic t_report predict_report(t_sweep_item it);
        t_report r;
        int      k;
        int      v;
        int      wm;
        int      bm;
        r = '0;
        if (it.op == OP_CLEAR) begin
            clear_calibration();
            r.thr = SMP_W'(thr_m[0]);
            r.lo  = SMP_W'(lo_m[0]);
            r.hi  = SMP_W'(hi_m[0]);
        end else begin
            k = int'(it.idx);
            v = int'(it.smp);
            if (sweeps_m == HALF_SWEEP)
                thr_m[k] = (hi_m[k] + lo_m[k]) / 2;
            if (sweeps_m > HALF_SWEEP && sweeps_m < SWEEPS) begin
                if (v < thr_m[k] && wcnt_m[k] < int'(COUNT_LIMIT) &&
                    wsum_m[k] + v <= SUM_CAP) begin
                    wsum_m[k] += v;
                    wcnt_m[k] += 1;
                end
                if (v > thr_m[k] && bcnt_m[k] < int'(COUNT_LIMIT) &&
                    bsum_m[k] + v <= SUM_CAP) begin
                    bsum_m[k] += v;
                    bcnt_m[k] += 1;
                end
            end
            if (sweeps_m == SWEEPS - 1) begin
                wm = (wcnt_m[k] != 0) ? wsum_m[k] / wcnt_m[k] : 0;
                bm = (bcnt_m[k] != 0) ? bsum_m[k] / bcnt_m[k] : 0;
                thr_m[k] = (wm + bm) / 2;
            end
            if (v > hi_m[k])
                hi_m[k] = v;
            if (v < lo_m[k])
                lo_m[k] = v;
            r.sensor = it.idx;
            r.thr    = SMP_W'(thr_m[k]);
            r.lo     = SMP_W'(lo_m[k]);
            r.hi     = SMP_W'(hi_m[k]);
            if (it.eos && sweeps_m < SWEEPS)
                sweeps_m++;
        end
        r.cal = (sweeps_m >= SWEEPS);
        return r;
    endfunction

    task automatic add_item(logic op, logic [IDX_W-1:0] idx, logic [SMP_W-1:0] smp, logic eos);
        t_sweep_item it;
        it.op  = op;
        it.idx = idx;
        it.smp = smp;
        it.eos = eos;
        pending_items.push_back(it);
    endtask

    // bias: 0 bimodal mix, 1 dark-biased low, 2 bright-biased high
    function automatic logic [SMP_W-1:0] pick_sample(int bias);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return '0;
        if (r < 6)
            return '1;
        if (bias == 1 || (bias == 0 && r < 50))
            return SMP_W'($urandom_range(250));
        if (bias == 2)
            return SMP_W'($urandom_range(1023, 950));
        if (r < 95)
            return SMP_W'($urandom_range(1023, 770));
        return SMP_W'($urandom);
    endfunction

    // One full calibration: clear, sweeps up to and past the final one.
    // Focus runs pile samples on sensors 0 and 1 to hit the class limits.
    task automatic add_run(bit focus);
        int               len;
        int               bias;
        logic [IDX_W-1:0] k;
        logic             last;
        bit               accum;
        add_item(OP_CLEAR, IDX_W'($urandom), SMP_W'($urandom), 1'($urandom));
        for (int s = 0; s < SWEEPS + 12; s++) begin
            accum = (s > HALF_SWEEP) && (s < SWEEPS);
            if (accum)
                len = focus ? $urandom_range(5, 3) : $urandom_range(3, 1);
            else
                len = $urandom_range(2, 1);
            for (int j = 0; j < len; j++) begin
                if (focus && accum) begin
                    if ($urandom_range(99) < 60) begin
                        k    = IDX_W'(1);
                        bias = 1;
                    end else begin
                        k    = IDX_W'(0);
                        bias = 2;
                    end
                end else begin
                    k    = IDX_W'($urandom);
                    bias = 0;
                end
                last = (j == len - 1);
                if (!focus && $urandom_range(29) == 0)
                    last = ~last;
                add_item(OP_SAMPLE, k, pick_sample(bias), last);
            end
        end
    endtask

    // output check, then input capture for the predictor
    always @(posedge i_clk) begin : monitor
        t_report got;
        t_report want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.sensor = m_axis_tdata[2:0];
            got.thr    = m_axis_tdata[12:3];
            got.lo     = m_axis_tdata[22:13];
            got.hi     = m_axis_tdata[32:23];
            got.cal    = m_axis_tuser;
            reports_seen++;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: sensor=%0d thr=%0d lo=%0d hi=%0d cal=%0b",
                             got.sensor, got.thr, got.lo, got.hi, got.cal);
            end else begin
                want = expected_reports.pop_front();
                if (got.sensor !== want.sensor || got.thr !== want.thr || got.lo !== want.lo ||
                    got.hi !== want.hi || got.cal !== want.cal) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("report %0d mismatch: exp sensor=%0d thr=%0d lo=%0d hi=%0d ",
                               reports_seen, want.sensor, want.thr, want.lo, want.hi);
                        $display("cal=%0b, act sensor=%0d thr=%0d lo=%0d hi=%0d cal=%0b",
                                 want.cal, got.sensor, got.thr, got.lo, got.hi, got.cal);
                    end
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready) begin
            expected_reports.push_back(predict_report(pending_items[0]));
            in_taken = 1'b1;
        end
    end

    // holds each transaction until accepted
    always @(negedge i_clk) begin : driver
        t_sweep_item it;
        if (in_taken) begin
            it       = pending_items.pop_front();
            in_taken = 1'b0;
            offering = 1'b0;
        end
        if (!offering && i_rst_n && pending_items.size() > 0 &&
            (burst_mode || $urandom_range(99) >= IDLE_PCT))
            offering = 1'b1;
        if (offering) begin
            it = pending_items[0];
            s_axis_tdata <= IN_TDATA_W'({it.smp, it.idx});
            s_axis_tuser <= it.op;
            s_axis_tlast <= it.eos;
        end
        s_axis_tvalid <= offering;
    end

    always @(negedge i_clk) begin : receiver
        if (hold_left > 0)
            m_axis_tready <= 1'b0;
        else if (burst_mode)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // one long back-pressure window
    always @(negedge i_clk) begin : hold_off
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reports_seen >= 120) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [SMP_W-1:0] edge_vals[8];
        edge_vals = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd1022, 10'd512, 10'd511};
        clear_calibration();

        // clear with junk fields, every sensor at edge values, bounds on one sensor
        add_item(OP_CLEAR, 3'd7, 10'd1023, 1'b1);
        for (int k = 0; k < SENSORS; k++)
            add_item(OP_SAMPLE, IDX_W'(k), edge_vals[k], k == SENSORS - 1);
        add_item(OP_SAMPLE, 3'd0, 10'd1023, 1'b0);
        add_item(OP_SAMPLE, 3'd0, 10'd0, 1'b1);
        add_item(OP_CLEAR, 3'd0, 10'd0, 1'b0);
        add_item(OP_SAMPLE, 3'd7, 10'h2AA, 1'b1);
        add_item(OP_SAMPLE, 3'd5, 10'h155, 1'b0);

        add_run(1'b0);
        add_run(1'b1);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
